// File: rtl/oll_pkg.sv
// ---------------------------------------------------------------------------
// Lexer package
// Token codes, keyword spellings, the token record and the character-class
// helpers shared by the lexer.
// ---------------------------------------------------------------------------
package oll_pkg;

   localparam int KW_MAX_LEN = 8;   // longest keyword that is compared
   localparam int WLEN_BITS  = 4;   // stored length, KW_MAX_LEN + 1 means too long
   localparam int WIDX_BITS  = 3;   // index into the word buffer
   localparam int KIND_BITS  = 5;
   localparam int OPOS_BITS  = 16;  // width of the positions on the result port
   localparam int KW_COUNT   = 13;

   // Token kinds.
   localparam logic [KIND_BITS-1:0] KIND_COMMA  = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_SEMI   = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_PLUS   = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_MINUS  = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_EQUAL  = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_COLON  = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_STAR   = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_SLASH  = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_LT     = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_LE     = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_GT     = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_GE     = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_NUM    = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_IDENT  = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_END    = 5'd29;
   localparam logic [KIND_BITS-1:0] KIND_ERR    = 5'd30;

   // Keyword spellings, right aligned: the first character of a spelling of
   // length n sits in bits [8n-1 -: 8].
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("var"), 64'("maximize"), 64'("maximise"), 64'("minimize"),
      64'("minimise"), 64'("subject"), 64'("to"), 64'("and"), 64'("or"),
      64'("nat"), 64'("int"), 64'("real"), 64'("img")
   };
   localparam logic [WLEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd8, 4'd8, 4'd8, 4'd8, 4'd7, 4'd2, 4'd3, 4'd2, 4'd3, 4'd3, 4'd4, 4'd3
   };
   localparam logic [KIND_BITS-1:0] KW_KIND [KW_COUNT] = '{
      5'd18, 5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25,
      5'd26, 5'd27, 5'd28
   };

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [OPOS_BITS-1:0] start_pos;
      logic [OPOS_BITS-1:0] end_pos;
      logic                 last;
   } token_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || (c == 8'h0A) || (c == 8'h09) || (c == 8'h0D);
   endfunction

   // Single-character punctuators; anything else is an error token.
   function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
      logic [KIND_BITS-1:0] k;
      case (c)
         ",":     k = KIND_COMMA;
         ";":     k = KIND_SEMI;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "=":     k = KIND_EQUAL;
         ":":     k = KIND_COLON;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         default: k = KIND_ERR;
      endcase
      return k;
   endfunction

endpackage

// File: rtl/optimization_language_lexer.sv
// ---------------------------------------------------------------------------
// Optimization language lexer
// Streaming tokenizer: one source byte or an end marker per request, zero to
// two tokens with kind and start/end positions per request.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Contents
//   req      in         req_tvalid/tready     tdata = source byte, tlast = end of input
//   rsp      out        rsp_tvalid/tready     tdata = start, end; tuser = kind;
//                                             tlast = last token of its request
//
// A request is taken into an input register, decoded from there and its
// tokens land in a registered three-entry result queue. One request per
// cycle is sustained while each request yields at most one token and the
// result side takes every token; a request with two tokens leaves them one
// after the other through the single result port. Synchronous reset puts
// the scanner to idle with position zero; there is no clearing pass.
// Result-side stalls reach the request side only through the queue fill.
//
module optimization_language_lexer
   import oll_pkg::*;
#(
   parameter int POS_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // at_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] token_start, [31:16] token_end
   output logic [4:0]  rsp_tuser,   // [4:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   localparam int EXT_BITS = (POS_BITS > OPOS_BITS) ? POS_BITS : OPOS_BITS + 1;
   localparam int Q_DEPTH  = 3;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_IDENT, MODE_INT, MODE_FRAC, MODE_LT, MODE_GT
   } mode_type;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_end_ff;

   // Scanner state.
   mode_type              mode_ff, mode_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS_BITS-1:0]   begin_ff, begin_in;
   logic [WLEN_BITS-1:0]  wlen_ff, wlen_in;
   logic [7:0]            word_ff [KW_MAX_LEN];

   logic                  word_wr;
   logic [WIDX_BITS-1:0]  word_idx;
   logic [POS_BITS-1:0]   pos_nx;
   logic [KIND_BITS-1:0]  kw_kind;
   logic                  fl_pending;
   logic [KIND_BITS-1:0]  fl_kind;
   logic                  fl_v, ot_v, handled;
   token_type             fl_tok, ot_tok, tok0, tok1;
   logic [1:0]            tok_cnt;

   // Result queue, head in entry zero.
   token_type  q_ff [Q_DEPTH];
   token_type  q_in [Q_DEPTH];
   token_type  q_sh [Q_DEPTH];
   logic [1:0] cnt_ff, cnt_in, cnt_mid;
   logic       pop, fire;

   function automatic logic [OPOS_BITS-1:0] clamp_pos(input logic [POS_BITS-1:0] p);
      logic [EXT_BITS-1:0] pe;
      pe = EXT_BITS'(p);
      if (pe > EXT_BITS'({OPOS_BITS{1'b1}})) begin
         return {OPOS_BITS{1'b1}};
      end
      return pe[OPOS_BITS-1:0];
   endfunction

   // The decode stage runs only when the queue can take two tokens.
   assign fire        = in_valid_ff && (cnt_ff <= 2'd1);
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   // Keyword lookup: every spelling is compared in parallel against the
   // stored characters; the length must match exactly.
   always_comb begin
      logic ok;
      kw_kind = KIND_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         ok = (wlen_ff == KW_LEN[i]);
         for (int j = 0; j < KW_MAX_LEN; j++) begin
            if (j < int'(KW_LEN[i])) begin
               ok = ok && (word_ff[j] == KW_TEXT[i][8*(int'(KW_LEN[i])-1-j) +: 8]);
            end
         end
         if (ok) begin
            kw_kind = KW_KIND[i];
         end
      end
   end

   // Kind of the pending multi-character token, if any.
   always_comb begin
      fl_pending = 1'b1;
      case (mode_ff)
         MODE_IDENT: fl_kind = kw_kind;
         MODE_INT:   fl_kind = KIND_NUM;
         MODE_FRAC:  fl_kind = KIND_NUM;
         MODE_LT:    fl_kind = KIND_LT;
         MODE_GT:    fl_kind = KIND_GT;
         default: begin
            fl_kind    = KIND_NUM;
            fl_pending = 1'b0;
         end
      endcase
   end

   assign pos_nx = (pos_ff == {POS_BITS{1'b1}}) ? pos_ff : pos_ff + 1'b1;

   // Scanner decode. The flushed token, when there is one, always comes first.
   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      wlen_in  = wlen_ff;
      word_wr  = 1'b0;
      word_idx = wlen_ff[WIDX_BITS-1:0];
      handled  = 1'b0;
      fl_v     = 1'b0;
      ot_v     = 1'b0;
      fl_tok   = '{kind: fl_kind, start_pos: clamp_pos(begin_ff),
                   end_pos: clamp_pos(pos_ff), last: 1'b0};
      ot_tok   = '{kind: KIND_ERR, start_pos: clamp_pos(pos_ff),
                   end_pos: clamp_pos(pos_nx), last: 1'b0};

      if (in_end_ff) begin
         fl_v           = fl_pending;
         ot_v           = 1'b1;
         ot_tok.kind    = KIND_END;
         ot_tok.end_pos = clamp_pos(pos_ff);
         mode_in        = MODE_IDLE;
         pos_in         = '0;
         begin_in       = '0;
         wlen_in        = '0;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (is_letter(in_char_ff) || is_digit(in_char_ff) ||
                   (in_char_ff == "_") || (in_char_ff == "'")) begin
                  handled = 1'b1;
                  if (wlen_ff < WLEN_BITS'(KW_MAX_LEN)) begin
                     word_wr = 1'b1;
                     wlen_in = wlen_ff + 1'b1;
                  end else begin
                     wlen_in = WLEN_BITS'(KW_MAX_LEN + 1);
                  end
               end
            end
            MODE_INT: begin
               if (is_digit(in_char_ff) || (in_char_ff == "_")) begin
                  handled = 1'b1;
               end else if (in_char_ff == ".") begin
                  handled = 1'b1;
                  mode_in = MODE_FRAC;
               end
            end
            MODE_FRAC: begin
               if (is_digit(in_char_ff)) begin
                  handled = 1'b1;
               end
            end
            MODE_LT, MODE_GT: begin
               if (in_char_ff == "=") begin
                  handled          = 1'b1;
                  ot_v             = 1'b1;
                  ot_tok.kind      = (mode_ff == MODE_LT) ? KIND_LE : KIND_GE;
                  ot_tok.start_pos = clamp_pos(begin_ff);
                  mode_in          = MODE_IDLE;
               end
            end
            default: begin
            end
         endcase

         // A character that cannot continue the pending token closes it and
         // is then scanned as if the lexer were idle.
         if (!handled) begin
            fl_v    = fl_pending;
            mode_in = MODE_IDLE;
            if (is_space(in_char_ff)) begin
               mode_in = MODE_IDLE;
            end else if (is_letter(in_char_ff)) begin
               mode_in  = MODE_IDENT;
               begin_in = pos_ff;
               word_wr  = 1'b1;
               word_idx = '0;
               wlen_in  = WLEN_BITS'(1);
            end else if (is_digit(in_char_ff)) begin
               mode_in  = MODE_INT;
               begin_in = pos_ff;
            end else if (in_char_ff == "<") begin
               mode_in  = MODE_LT;
               begin_in = pos_ff;
            end else if (in_char_ff == ">") begin
               mode_in  = MODE_GT;
               begin_in = pos_ff;
            end else begin
               ot_v        = 1'b1;
               ot_tok.kind = punct_kind(in_char_ff);
            end
         end
         pos_in = pos_nx;
      end
   end

   // Pack the tokens of this request and mark the final one.
   always_comb begin
      tok_cnt = 2'(fl_v) + 2'(ot_v);
      tok0    = fl_v ? fl_tok : ot_tok;
      tok1    = ot_tok;
      if (tok_cnt == 2'd2) begin
         tok1.last = 1'b1;
      end else begin
         tok0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
         wlen_ff  <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
         wlen_ff  <= wlen_in;
      end
   end

   // Word buffer: holds the leading characters of the identifier in progress.
   always_ff @(posedge clock) begin
      if (fire && word_wr) begin
         word_ff[word_idx] <= in_char_ff;
      end
   end

   // Result queue: shift on pop, then append the new tokens behind the rest.
   always_comb begin
      pop     = (cnt_ff != 2'd0) && rsp_tready;
      cnt_mid = cnt_ff - 2'(pop);
      for (int i = 0; i < Q_DEPTH - 1; i++) begin
         q_sh[i] = pop ? q_ff[i+1] : q_ff[i];
      end
      q_sh[Q_DEPTH-1] = q_ff[Q_DEPTH-1];
      q_in   = q_sh;
      cnt_in = cnt_mid;
      if (fire) begin
         cnt_in = cnt_mid + tok_cnt;
         for (int i = 0; i < Q_DEPTH; i++) begin
            if ((tok_cnt != 2'd0) && (2'(i) == cnt_mid)) begin
               q_in[i] = tok0;
            end
            if ((tok_cnt == 2'd2) && (2'(i) == cnt_mid + 2'd1)) begin
               q_in[i] = tok1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {q_ff[0].end_pos, q_ff[0].start_pos};
   assign rsp_tuser  = q_ff[0].kind;
   assign rsp_tlast  = q_ff[0].last;

`ifndef SYNTH
   // The pending token never starts after the current position.
   a_begin_le_pos : assert property (@(posedge clock) disable iff (reset)
      begin_ff <= pos_ff)
      else $error("token start ahead of position");

   // The stored word length never goes past the too-long marker.
   a_wlen_range : assert property (@(posedge clock) disable iff (reset)
      wlen_ff <= WLEN_BITS'(KW_MAX_LEN + 1))
      else $error("word length out of range");

   // An end request always leaves at least its end token in the queue.
   a_end_token : assert property (@(posedge clock) disable iff (reset)
      fire && in_end_ff |=> cnt_ff != 2'd0)
      else $error("end request produced no token");

   // After an end request the scanner restarts at position zero.
   a_end_restart : assert property (@(posedge clock) disable iff (reset)
      fire && in_end_ff |=> pos_ff == '0 && mode_ff == MODE_IDLE)
      else $error("scanner not restarted after end");
`endif

endmodule

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// Lexer testbench
// Feeds source bytes and end markers into the lexer, predicts each token with
// its own scanner model or a directed row, checks the stream field by field
// under several patterns of idling, stalling and result-side hold-off.
// ---------------------------------------------------------------------------
module tb_top
   import oll_pkg::*;
();

   localparam int POS_W       = 16;
   localparam int TAIL_CYCLES = 16;     // idle tail after the last drain, before the summary
   localparam int PHASE_ITEMS = 400;

   localparam logic [7:0] TAB = 8'h09;
   localparam logic [7:0] LF  = 8'h0A;
   localparam logic [7:0] CR  = 8'h0D;

   // Keyword token kinds; both spellings of maximize and minimize share a code.
   localparam logic [KIND_BITS-1:0] KIND_VAR      = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_MAXIMIZE = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_MINIMIZE = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_SUBJECT  = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_TO       = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_AND      = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_OR       = 5'd24;
   localparam logic [KIND_BITS-1:0] KIND_NAT      = 5'd25;
   localparam logic [KIND_BITS-1:0] KIND_INT      = 5'd26;
   localparam logic [KIND_BITS-1:0] KIND_REAL     = 5'd27;
   localparam logic [KIND_BITS-1:0] KIND_IMG      = 5'd28;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_INT, SCAN_FRAC, SCAN_LT, SCAN_GT
   } scan_mode_type;

   // One row of the directed table. When typed is set, tok is the single
   // token the request must give; otherwise the scanner model decides.
   typedef struct packed {
      logic [7:0] ch;
      logic       at_end;
      logic       typed;
      token_type  tok;
   } stim_row_type;

   localparam int N_ROWS = 27;
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      // All twelve punctuators back to back, the first one straight after reset.
      '{",", 1'b0, 1'b1, '{KIND_COMMA, 16'd0, 16'd1, 1'b1}},
      '{";", 1'b0, 1'b0, '0}, '{"(", 1'b0, 1'b0, '0}, '{")", 1'b0, 1'b0, '0},
      '{"{", 1'b0, 1'b0, '0}, '{"}", 1'b0, 1'b0, '0}, '{"+", 1'b0, 1'b0, '0},
      '{"-", 1'b0, 1'b0, '0}, '{"=", 1'b0, 1'b0, '0}, '{":", 1'b0, 1'b0, '0},
      '{"*", 1'b0, 1'b0, '0}, '{"/", 1'b0, 1'b0, '0},
      // Bytes that give an error token: the top byte value and a lone dot.
      '{8'hFF, 1'b0, 1'b1, '{KIND_ERR, 16'd12, 16'd13, 1'b1}},
      '{".", 1'b0, 1'b1, '{KIND_ERR, 16'd13, 16'd14, 1'b1}},
      // <=, then < cut short by >, then >=, then > cut short by a digit.
      '{"<", 1'b0, 1'b0, '0}, '{"=", 1'b0, 1'b0, '0}, '{"<", 1'b0, 1'b0, '0},
      '{">", 1'b0, 1'b0, '0}, '{"=", 1'b0, 1'b0, '0}, '{">", 1'b0, 1'b0, '0},
      // A number that ends with its dot, closed by a blank.
      '{"9", 1'b0, 1'b0, '0}, '{".", 1'b0, 1'b0, '0}, '{" ", 1'b0, 1'b0, '0},
      // A keyword still pending at end of input: keyword and end token together.
      '{"o", 1'b0, 1'b0, '0}, '{"r", 1'b0, 1'b0, '0}, '{8'hA5, 1'b1, 1'b0, '0},
      // An end marker on an empty stream.
      '{8'h00, 1'b1, 1'b1, '{KIND_END, 16'd0, 16'd0, 1'b1}}
   };

   string punct_text = ",;(){}+-=:*/";
   string kw_spell [KW_COUNT] = '{
      "var", "maximize", "maximise", "minimize", "minimise", "subject", "to",
      "and", "or", "nat", "int", "real", "img"
   };
   logic [KIND_BITS-1:0] kw_code [KW_COUNT] = '{
      KIND_VAR, KIND_MAXIMIZE, KIND_MAXIMIZE, KIND_MINIMIZE, KIND_MINIMIZE,
      KIND_SUBJECT, KIND_TO, KIND_AND, KIND_OR, KIND_NAT, KIND_INT, KIND_REAL,
      KIND_IMG
   };
   logic [7:0] blank_bytes [4] = '{" ", TAB, LF, CR};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] ch
   logic        req_tlast;   // at_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [15:0] token_start, [31:16] token_end
   logic [4:0]  rsp_tuser;   // [4:0] token_kind
   logic        rsp_tlast;   // last_of_run

   optimization_language_lexer #(
      .POS_BITS(POS_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Scanner model state.
   scan_mode_type    lex_mode;
   logic [POS_W-1:0] lex_pos;
   logic [POS_W-1:0] lex_begin;
   logic [7:0]       lex_word [KW_MAX_LEN];
   logic [3:0]       lex_word_len;

   token_type step_tokens [$];     // tokens of the request being modeled
   token_type pending_tokens [$];  // tokens still owed by the lexer, oldest first

   // Knobs shared with the result-side process. They are set only at a rising
   // edge, while that process acts only at falling edges.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_cycles    = 0;

   // Current directed row, read by the monitor when the request is taken.
   logic      row_typed;
   token_type row_token;

   int n_errors    = 0;
   int n_requests  = 0;
   int n_end_marks = 0;
   int n_tokens    = 0;
   int n_sent      = 0;

   function automatic logic alpha_byte(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic digit_byte(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // Positions stick at their ceiling instead of wrapping.
   function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] p);
      return (&p) ? p : p + 1'b1;
   endfunction

   function automatic logic [15:0] port_pos(input logic [POS_W-1:0] p);
      return (p > 65535) ? 16'hFFFF : 16'(p);
   endfunction

   function automatic void add_token(input logic [KIND_BITS-1:0] kind,
                                     input logic [POS_W-1:0] s,
                                     input logic [POS_W-1:0] e);
      token_type t;
      t.kind      = kind;
      t.start_pos = port_pos(s);
      t.end_pos   = port_pos(e);
      t.last      = 1'b0;
      step_tokens = {step_tokens, t};
   endfunction

   // Appends a token to the list of tokens the lexer still owes.
   function automatic void owe_token(input token_type t);
      pending_tokens = {pending_tokens, t};
   endfunction

   // A word turns into a keyword only on an exact match of length and bytes.
   function automatic logic [KIND_BITS-1:0] word_code();
      logic hit;
      if (lex_word_len > KW_MAX_LEN) return KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (kw_spell[i].len() == lex_word_len) begin
            hit = 1'b1;
            for (int j = 0; j < kw_spell[i].len(); j++) begin
               if (lex_word[j] != kw_spell[i][j]) hit = 1'b0;
            end
            if (hit) return kw_code[i];
         end
      end
      return KIND_IDENT;
   endfunction

   function automatic void flush_pending();
      case (lex_mode)
         SCAN_WORD:           add_token(word_code(), lex_begin, lex_pos);
         SCAN_INT, SCAN_FRAC: add_token(KIND_NUM, lex_begin, lex_pos);
         SCAN_LT:             add_token(KIND_LT, lex_begin, lex_pos);
         SCAN_GT:             add_token(KIND_GT, lex_begin, lex_pos);
         default: ;
      endcase
      lex_mode = SCAN_IDLE;
   endfunction

   function automatic void keep_char(input logic [7:0] c);
      if (lex_word_len < KW_MAX_LEN) begin
         lex_word[lex_word_len[2:0]] = c;
         lex_word_len = lex_word_len + 1'b1;
      end else begin
         lex_word_len = 4'(KW_MAX_LEN + 1);
      end
   endfunction

   function automatic void lex_reset();
      lex_mode     = SCAN_IDLE;
      lex_pos      = '0;
      lex_begin    = '0;
      lex_word_len = '0;
      foreach (lex_word[i]) lex_word[i] = '0;
   endfunction

   // Models one request and leaves its tokens in step_tokens.
   function automatic void lex_step(input logic [7:0] c, input logic fin);
      logic                 taken;
      logic [KIND_BITS-1:0] k;
      token_type            t;
      step_tokens.delete();
      taken = 1'b0;
      if (fin) begin
         flush_pending();
         add_token(KIND_END, lex_pos, lex_pos);
         lex_pos      = '0;
         lex_begin    = '0;
         lex_word_len = '0;
      end else begin
         case (lex_mode)
            SCAN_WORD:
               if (alpha_byte(c) || digit_byte(c) || c == "_" || c == "'") begin
                  keep_char(c);
                  taken = 1'b1;
               end
            SCAN_INT:
               if (digit_byte(c) || c == "_") begin
                  taken = 1'b1;
               end else if (c == ".") begin
                  lex_mode = SCAN_FRAC;
                  taken    = 1'b1;
               end
            SCAN_FRAC:
               if (digit_byte(c)) taken = 1'b1;
            SCAN_LT, SCAN_GT:
               if (c == "=") begin
                  add_token((lex_mode == SCAN_LT) ? KIND_LE : KIND_GE, lex_begin,
                            bump(lex_pos));
                  lex_mode = SCAN_IDLE;
                  taken    = 1'b1;
               end
            default: lex_mode = SCAN_IDLE;
         endcase
         // A byte that does not continue the pending token closes it and is
         // then scanned as if from idle.
         if (!taken) begin
            flush_pending();
            if (c == " " || c == TAB || c == LF || c == CR) begin
               // blanks only move the position
            end else if (alpha_byte(c)) begin
               lex_mode     = SCAN_WORD;
               lex_begin    = lex_pos;
               lex_word_len = '0;
               keep_char(c);
            end else if (digit_byte(c)) begin
               lex_mode  = SCAN_INT;
               lex_begin = lex_pos;
            end else if (c == "<") begin
               lex_mode  = SCAN_LT;
               lex_begin = lex_pos;
            end else if (c == ">") begin
               lex_mode  = SCAN_GT;
               lex_begin = lex_pos;
            end else begin
               k = KIND_ERR;
               for (int i = 0; i < punct_text.len(); i++) begin
                  if (punct_text[i] == c) k = KIND_COMMA + 5'(i);
               end
               add_token(k, lex_pos, bump(lex_pos));
            end
         end
         lex_pos = bump(lex_pos);
      end
      if (step_tokens.size() > 0) begin
         t = step_tokens[step_tokens.size() - 1];
         t.last = 1'b1;
         step_tokens[step_tokens.size() - 1] = t;
      end
   endfunction

   function automatic void compare_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
         n_errors++;
      end
   endfunction

   // Monitor: models each request as it is taken and checks each token as it
   // leaves. Modeling comes first, so the order within the edge is fixed.
   always @(posedge clock) begin : monitor
      token_type want;
      if (reset) begin
         lex_reset();
         pending_tokens.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            lex_step(req_tdata, req_tlast);
            n_requests++;
            if (req_tlast) n_end_marks++;
            if (row_typed) begin
               owe_token(row_token);
            end else begin
               foreach (step_tokens[i]) owe_token(step_tokens[i]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            n_tokens++;
            if (pending_tokens.size() == 0) begin
               $display("%0t: token kind %0d start %0d end %0d last %0d with none expected",
                        $time, rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
               n_errors++;
            end else begin
               want = pending_tokens.pop_front();
               compare_field("token kind", want.kind, rsp_tuser);
               compare_field("token start", want.start_pos, rsp_tdata[15:0]);
               compare_field("token end", want.end_pos, rsp_tdata[31:16]);
               compare_field("last of request", want.last, rsp_tlast);
            end
         end
      end
   end

   // Result side: a long hold-off when one is asked for, random stalls otherwise.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Offers one request, with random idle cycles ahead of it, and returns at
   // the falling edge after it was taken. Valid stays high on return so that
   // back-to-back requests need no second assignment in one step.
   task automatic send_request(input logic [7:0] c, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      n_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_word_byte(input logic first);
      int pick;
      pick = first ? $urandom_range(1) : $urandom_range(5);
      case (pick)
         0:       return 8'("a" + $urandom_range(25));
         1:       return 8'("A" + $urandom_range(25));
         2, 3:    return 8'("0" + $urandom_range(9));
         4:       return "_";
         default: return "'";
      endcase
   endfunction

   // One lexeme of the language, mostly well formed, now and then a stray
   // byte, an end marker or a near miss of a keyword. Half the time a blank
   // follows; otherwise the next lexeme abuts it and has to close it.
   task automatic random_lexeme();
      int    pick;
      int    len;
      string w;
      pick = $urandom_range(99);
      if (pick < 15) begin
         send_text(kw_spell[$urandom_range(KW_COUNT - 1)]);
      end else if (pick < 30) begin
         len = $urandom_range(12, 1);
         send_request(pick_word_byte(1'b1), 1'b0);
         for (int i = 1; i < len; i++) send_request(pick_word_byte(1'b0), 1'b0);
      end else if (pick < 45) begin
         len = $urandom_range(5, 1);
         send_request(8'("0" + $urandom_range(9)), 1'b0);
         for (int i = 1; i < len; i++) begin
            send_request(($urandom_range(3) == 0) ? "_" : 8'("0" + $urandom_range(9)), 1'b0);
         end
         if ($urandom_range(1)) begin
            send_request(".", 1'b0);
            len = $urandom_range(3);
            for (int i = 0; i < len; i++) send_request(8'("0" + $urandom_range(9)), 1'b0);
         end
      end else if (pick < 60) begin
         send_request(punct_text[$urandom_range(11)], 1'b0);
      end else if (pick < 70) begin
         send_request($urandom_range(1) ? "<" : ">", 1'b0);
         if ($urandom_range(1)) send_request("=", 1'b0);
      end else if (pick < 78) begin
         send_request(blank_bytes[$urandom_range(3)], 1'b0);
      end else if (pick < 88) begin
         send_request(8'($urandom_range(255)), 1'b0);
      end else if (pick < 92) begin
         send_request(8'($urandom_range(255)), 1'b1);
      end else begin
         // Keyword with an extra letter, cut by one, or capitalized.
         w = kw_spell[$urandom_range(KW_COUNT - 1)];
         case ($urandom_range(2))
            0:       w = {w, "s"};
            1:       w = w.substr(0, w.len() - 2);
            default: w[0] = w[0] - 8'h20;
         endcase
         send_text(w);
      end
      if ($urandom_range(1)) send_request(blank_bytes[$urandom_range(3)], 1'b0);
   endtask

   task automatic random_phase(input int n);
      int target;
      target = n_sent + n;
      while (n_sent < target) random_lexeme();
   endtask

   // Drops valid and waits until every token owed has come out.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0) @(negedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct, input int hold);
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      hold_cycles    = hold;
      @(negedge clock);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      row_typed  = 1'b0;
      row_token  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, no idling on either side.
      for (int r = 0; r < N_ROWS; r++) begin
         row_typed = DIRECTED_ROWS[r].typed;
         row_token = DIRECTED_ROWS[r].tok;
         send_request(DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].at_end);
      end
      row_typed = 1'b0;
      wait_drained();

      // Random lexemes under each idling pattern.
      random_phase(PHASE_ITEMS);
      wait_drained();
      set_idling(85, 0, 0);
      random_phase(PHASE_ITEMS);
      wait_drained();
      set_idling(0, 85, 0);
      random_phase(PHASE_ITEMS);
      wait_drained();
      set_idling(30, 30, 0);
      random_phase(PHASE_ITEMS);
      wait_drained();

      // Hold the result side off for a long stretch while pairs of requests keep
      // coming, a < and then a comma that gives two tokens, so the result queue
      // fills and the request side has to stall.
      set_idling(0, 0, 300);
      for (int i = 0; i < 30; i++) send_text("<,");
      wait_drained();

      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Checked %0d tokens from %0d requests (%0d end markers) under four",
               n_tokens, n_requests, n_end_marks);
      $display("idling patterns and one long result-side hold-off that filled the queue.");
      if (n_errors == 0) begin
         $display("[optimization_language_lexer] OK");
      end else begin
         $display("[optimization_language_lexer] ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_400_000;
      $display("Timed out with %0d tokens still owed.", pending_tokens.size());
      $display("[optimization_language_lexer] ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/oll_pkg.sv
rtl/optimization_language_lexer.sv
bench/tb_top.sv
